// ===== rtl/core/msh_pkg.sv =====
// ----------------------------------------------------------------------------
// Msh diverging interpolator package
// Shared constants, register indexes, CORDIC angle table and the word record
// that travels down the pipeline.
// ----------------------------------------------------------------------------
package msh_pkg;

  localparam int CORDIC_ITERATIONS = 16;
  localparam int SQRT_STEPS        = 16;
  localparam int DIV_STEPS         = 16;

  localparam logic [14:0]        S_THR       = 15'd410;
  localparam logic signed [17:0] PI_3        = 18'sd8579;
  localparam logic signed [17:0] PI_Q        = 18'sd25736;
  localparam logic signed [17:0] TWO_PI      = 18'sd51472;
  localparam logic signed [17:0] TWO_TWO_PI  = 18'sd102944;
  localparam logic [14:0]        PI_2        = 15'd12868;
  localparam logic [15:0]        MID_FLOOR   = 16'd22528;
  localparam logic [16:0]        M_MARGIN    = 17'd26;
  localparam logic [16:0]        ONE_Q15     = 17'd32768;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

  localparam logic [2:0] REG_FIRST_MAGNITUDE   = 3'd0;
  localparam logic [2:0] REG_FIRST_SATURATION  = 3'd1;
  localparam logic [2:0] REG_FIRST_HUE         = 3'd2;
  localparam logic [2:0] REG_SECOND_MAGNITUDE  = 3'd3;
  localparam logic [2:0] REG_SECOND_SATURATION = 3'd4;
  localparam logic [2:0] REG_SECOND_HUE        = 3'd5;

  typedef enum logic [1:0] {
    ADJ_NONE,
    ADJ_FIRST,
    ADJ_SECOND
  } adj_t;

  typedef struct packed {
    logic [15:0]        m1;
    logic [14:0]        s1;
    logic signed [17:0] h1;
    logic [15:0]        m2;
    logic [14:0]        s2;
    logic signed [17:0] h2;
    logic [15:0]        r;
    adj_t               sel;
    logic [15:0]        ms;
    logic [14:0]        ss;
    logic signed [15:0] hs;
    logic [15:0]        mu;
    logic               near;
    logic [31:0]        sq_rem;
    logic [31:0]        sq_res;
    logic signed [33:0] cx;
    logic signed [33:0] cy;
    logic signed [33:0] cz;
    logic [45:0]        num;
    logic signed [33:0] den;
    logic [31:0]        dabs;
    logic               dneg;
    logic               dzero;
    logic               dovf;
    logic [46:0]        rem;
    logic [15:0]        quo;
    logic [31:0]        pm1;
    logic [31:0]        pm2;
    logic [31:0]        ps1;
    logic [31:0]        ps2;
    logic signed [35:0] ph1;
    logic signed [35:0] ph2;
  } item_t;

  function automatic logic signed [33:0] atan_at(input logic [4:0] i);
    logic signed [33:0] v;
    case (i)
      5'd0:  v = 34'sd843314857;
      5'd1:  v = 34'sd497837829;
      5'd2:  v = 34'sd263043837;
      5'd3:  v = 34'sd133525159;
      5'd4:  v = 34'sd67021687;
      5'd5:  v = 34'sd33543516;
      5'd6:  v = 34'sd16775851;
      5'd7:  v = 34'sd8388437;
      5'd8:  v = 34'sd4194283;
      5'd9:  v = 34'sd2097149;
      5'd10: v = 34'sd1048576;
      5'd11: v = 34'sd524288;
      5'd12: v = 34'sd262144;
      5'd13: v = 34'sd131072;
      5'd14: v = 34'sd65536;
      5'd15: v = 34'sd32768;
      5'd16: v = 34'sd16384;
      5'd17: v = 34'sd8192;
      5'd18: v = 34'sd4096;
      5'd19: v = 34'sd2048;
      5'd20: v = 34'sd1024;
      5'd21: v = 34'sd512;
      5'd22: v = 34'sd256;
      5'd23: v = 34'sd128;
      default: v = 34'sd0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/core/msh_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// Square root cell
// One digit of a restoring integer square root per cell.
// ----------------------------------------------------------------------------
module msh_sqrt_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic            adv,
  input  logic [3:0]      idx,
  input  logic            in_valid,
  input  msh_pkg::item_t  din,
  output logic            out_valid,
  output msh_pkg::item_t  dout
);

  logic [32:0]    bitv;
  logic [32:0]    trial;
  msh_pkg::item_t nxt;

  always_comb begin
    bitv  = 33'd1 << (6'd30 - {1'b0, idx, 1'b0});
    trial = {1'b0, din.sq_res} + bitv;
    nxt   = din;
    if ({1'b0, din.sq_rem} >= trial) begin
      nxt.sq_rem = din.sq_rem - trial[31:0];
      nxt.sq_res = (din.sq_res >> 1) + bitv[31:0];
    end else begin
      nxt.sq_res = din.sq_res >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
    end
    if (adv) begin
      dout <= nxt;
    end
  end

endmodule

// ===== rtl/core/msh_cordic_cell.sv =====
// ----------------------------------------------------------------------------
// CORDIC rotation cell
// One micro-rotation of the sine CORDIC per cell.
// ----------------------------------------------------------------------------
module msh_cordic_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic            adv,
  input  logic [4:0]      idx,
  input  logic            in_valid,
  input  msh_pkg::item_t  din,
  output logic            out_valid,
  output msh_pkg::item_t  dout
);

  logic signed [33:0] x;
  logic signed [33:0] y;
  logic signed [33:0] xs;
  logic signed [33:0] ys;
  logic signed [33:0] at;
  msh_pkg::item_t     nxt;

  always_comb begin
    x   = din.cx;
    y   = din.cy;
    xs  = x >>> idx;
    ys  = y >>> idx;
    at  = msh_pkg::atan_at(idx);
    nxt = din;
    if (!din.cz[33]) begin
      nxt.cx = x - ys;
      nxt.cy = y + xs;
      nxt.cz = din.cz - at;
    end else begin
      nxt.cx = x + ys;
      nxt.cy = y - xs;
      nxt.cz = din.cz + at;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
    end
    if (adv) begin
      dout <= nxt;
    end
  end

endmodule

// ===== rtl/core/msh_div_cell.sv =====
// ----------------------------------------------------------------------------
// Divider cell
// One quotient bit of a restoring division per cell.
// ----------------------------------------------------------------------------
module msh_div_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic            adv,
  input  logic [3:0]      sh,
  input  logic            in_valid,
  input  msh_pkg::item_t  din,
  output logic            out_valid,
  output msh_pkg::item_t  dout
);

  logic [47:0]    dsh;
  msh_pkg::item_t nxt;

  always_comb begin
    dsh = {16'd0, din.dabs} << sh;
    nxt = din;
    if ({1'b0, din.rem} >= dsh) begin
      nxt.rem     = din.rem - dsh[46:0];
      nxt.quo[sh] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
    end
    if (adv) begin
      dout <= nxt;
    end
  end

endmodule

// ===== rtl/core/msh_diverging_color_interpolator_unit.sv =====
// ----------------------------------------------------------------------------
// Msh diverging color interpolator
// Interpolates between two Msh endpoints, bending through a neutral midpoint
// and spinning the hue of an unsaturated end.
// ----------------------------------------------------------------------------
//   channel  direction  handshake          payload
//   s_*      in         tvalid/tready      ratio
//   m_*      out        tvalid/tready      out_magnitude, out_saturation, out_hue
//   cfg_*    in         cfg_we             register index, data
//
// One word per cycle sustained while the output is not stalled; the pipeline is
// built from the square root, CORDIC and divider cell chains and their stage registers.
// The whole pipeline advances when the output register is empty or taken; a
// stall on m_tready holds every stage and drops s_tready in the same cycle.
// Reset clears the stage valid bits and the endpoint registers.
// ----------------------------------------------------------------------------
module msh_diverging_color_interpolator_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [15:0] ratio
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // [15:0] out_magnitude, [31:16] out_saturation,
                                 // [47:32] out_hue
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [15:0] cfg_data
);

  localparam int SQ = msh_pkg::SQRT_STEPS;
  localparam int CO = msh_pkg::CORDIC_ITERATIONS;
  localparam int DV = msh_pkg::DIV_STEPS;

  logic [15:0]        first_magnitude;
  logic [14:0]        first_saturation;
  logic signed [15:0] first_hue;
  logic [15:0]        second_magnitude;
  logic [14:0]        second_saturation;
  logic signed [15:0] second_hue;

  logic adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      first_magnitude   <= '0;
      first_saturation  <= '0;
      first_hue         <= '0;
      second_magnitude  <= '0;
      second_saturation <= '0;
      second_hue        <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        msh_pkg::REG_FIRST_MAGNITUDE:   first_magnitude   <= cfg_data;
        msh_pkg::REG_FIRST_SATURATION:  first_saturation  <= cfg_data[14:0];
        msh_pkg::REG_FIRST_HUE:         first_hue         <= cfg_data;
        msh_pkg::REG_SECOND_MAGNITUDE:  second_magnitude  <= cfg_data;
        msh_pkg::REG_SECOND_SATURATION: second_saturation <= cfg_data[14:0];
        msh_pkg::REG_SECOND_HUE:        second_hue        <= cfg_data;
        default: ;
      endcase
    end
  end

  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;

  // ---- entry: clamp, hue distance, bend and spin selection
  logic [15:0]        rc;
  logic signed [17:0] diff;
  logic signed [17:0] hdist;
  logic               bend;
  logic [15:0]        mid;
  logic [16:0]        r2;
  msh_pkg::item_t     a_next;

  always_comb begin
    rc   = (s_tdata > 16'd32768) ? 16'd32768 : s_tdata;
    diff = 18'(first_hue) - 18'(second_hue);
    if (diff < -msh_pkg::TWO_PI) begin
      hdist = diff + msh_pkg::TWO_TWO_PI;
    end else if (diff < 18'sd0) begin
      hdist = diff + msh_pkg::TWO_PI;
    end else if (diff >= msh_pkg::TWO_PI) begin
      hdist = diff - msh_pkg::TWO_PI;
    end else begin
      hdist = diff;
    end
    if (hdist > msh_pkg::PI_Q) begin
      hdist = msh_pkg::TWO_PI - hdist;
    end
    bend = (first_saturation > msh_pkg::S_THR) && (second_saturation > msh_pkg::S_THR)
           && (hdist > msh_pkg::PI_3);
    mid  = (first_magnitude > second_magnitude) ? first_magnitude : second_magnitude;
    if (mid < msh_pkg::MID_FLOOR) begin
      mid = msh_pkg::MID_FLOOR;
    end
    r2 = {rc, 1'b0};

    a_next    = '0;
    a_next.m1 = first_magnitude;
    a_next.s1 = first_saturation;
    a_next.h1 = 18'(first_hue);
    a_next.m2 = second_magnitude;
    a_next.s2 = second_saturation;
    a_next.h2 = 18'(second_hue);
    a_next.r  = rc;
    if (bend) begin
      if (rc < 16'd16384) begin
        a_next.m2 = mid;
        a_next.s2 = '0;
        a_next.h2 = '0;
        a_next.r  = r2[15:0];
      end else begin
        a_next.m1 = mid;
        a_next.s1 = '0;
        a_next.h1 = '0;
        a_next.r  = 16'(r2 - msh_pkg::ONE_Q15);
      end
    end

    if (a_next.s1 < msh_pkg::S_THR && a_next.s2 > msh_pkg::S_THR) begin
      a_next.sel = msh_pkg::ADJ_FIRST;
      a_next.ms  = a_next.m2;
      a_next.ss  = a_next.s2;
      a_next.hs  = a_next.h2[15:0];
      a_next.mu  = a_next.m1;
    end else begin
      if (a_next.s2 < msh_pkg::S_THR && a_next.s1 > msh_pkg::S_THR) begin
        a_next.sel = msh_pkg::ADJ_SECOND;
      end else begin
        a_next.sel = msh_pkg::ADJ_NONE;
      end
      a_next.ms = a_next.m1;
      a_next.ss = a_next.s1;
      a_next.hs = a_next.h1[15:0];
      a_next.mu = a_next.m2;
    end
  end

  logic           a_v;
  msh_pkg::item_t a;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
    end else if (adv) begin
      a_v <= s_tvalid;
    end
    if (adv) begin
      a <= a_next;
    end
  end

  // ---- squares and CORDIC seed
  logic [31:0]        mu_sq;
  logic [31:0]        ms_sq;
  logic signed [16:0] ang;
  msh_pkg::item_t     b_next;

  always_comb begin
    mu_sq  = a.mu * a.mu;
    ms_sq  = a.ms * a.ms;
    ang    = (a.ss > msh_pkg::PI_2) ? 17'sd25736 - 17'($signed({2'b00, a.ss}))
                                    : 17'($signed({2'b00, a.ss}));
    b_next        = a;
    b_next.near   = ({1'b0, a.ms} + msh_pkg::M_MARGIN) >= {1'b0, a.mu};
    b_next.sq_rem = mu_sq - ms_sq;
    b_next.sq_res = '0;
    b_next.cx     = msh_pkg::CORDIC_GAIN;
    b_next.cy     = '0;
    b_next.cz     = 34'(ang) <<< 17;
  end

  logic           sq_v [0:SQ];
  msh_pkg::item_t sq_i [0:SQ];

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_v[0] <= 1'b0;
    end else if (adv) begin
      sq_v[0] <= a_v;
    end
    if (adv) begin
      sq_i[0] <= b_next;
    end
  end

  for (genvar k = 0; k < SQ; k++) begin : g_sqrt
    msh_sqrt_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .adv      (adv),
      .idx      (4'(k)),
      .in_valid (sq_v[k]),
      .din      (sq_i[k]),
      .out_valid(sq_v[k+1]),
      .dout     (sq_i[k+1])
    );
  end

  logic           co_v [0:CO];
  msh_pkg::item_t co_i [0:CO];

  assign co_v[0] = sq_v[SQ];
  assign co_i[0] = sq_i[SQ];

  for (genvar k = 0; k < CO; k++) begin : g_cordic
    msh_cordic_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .adv      (adv),
      .idx      (5'(k)),
      .in_valid (co_v[k]),
      .din      (co_i[k]),
      .out_valid(co_v[k+1]),
      .dout     (co_i[k+1])
    );
  end

  // ---- sine rounding, numerator and denominator
  logic signed [33:0] sin_sum;
  logic signed [18:0] sin_q;
  logic signed [35:0] den_full;
  logic [30:0]        num_core;
  msh_pkg::item_t     p_next;

  always_comb begin
    sin_sum  = co_i[CO].cy + 34'sd16384;
    sin_q    = sin_sum[33:15];
    den_full = $signed({1'b0, co_i[CO].ms}) * sin_q;
    num_core = co_i[CO].ss * co_i[CO].sq_res[15:0];
    p_next     = co_i[CO];
    p_next.num = {num_core, 15'd0};
    p_next.den = den_full[33:0];
  end

  logic           p_v;
  msh_pkg::item_t p;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_v <= 1'b0;
    end else if (adv) begin
      p_v <= co_v[CO];
    end
    if (adv) begin
      p <= p_next;
    end
  end

  // ---- divider setup
  logic [33:0]    den_mag;
  msh_pkg::item_t e_next;

  always_comb begin
    den_mag      = p.den[33] ? 34'(-p.den) : 34'(p.den);
    e_next       = p;
    e_next.dneg  = p.den[33];
    e_next.dzero = (p.den == 34'sd0);
    e_next.dabs  = den_mag[31:0];
    e_next.dovf  = {2'b00, p.num} >= {den_mag[31:0], 16'd0};
    e_next.rem   = {1'b0, p.num};
    e_next.quo   = '0;
  end

  logic           dv_v [0:DV];
  msh_pkg::item_t dv_i [0:DV];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_v[0] <= 1'b0;
    end else if (adv) begin
      dv_v[0] <= p_v;
    end
    if (adv) begin
      dv_i[0] <= e_next;
    end
  end

  for (genvar k = 0; k < DV; k++) begin : g_div
    msh_div_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .adv      (adv),
      .sh       (4'(DV - 1 - k)),
      .in_valid (dv_v[k]),
      .din      (dv_i[k]),
      .out_valid(dv_v[k+1]),
      .dout     (dv_i[k+1])
    );
  end

  // ---- spin saturation and hue adjustment
  msh_pkg::item_t     dq;
  logic signed [17:0] spin;
  logic signed [17:0] hs_w;
  logic signed [17:0] hadj;
  msh_pkg::item_t     f_next;

  always_comb begin
    dq = dv_i[DV];
    if (dq.dzero) begin
      spin = 18'sd32767;
    end else if (!dq.dneg) begin
      spin = (dq.dovf || dq.quo > 16'd32767) ? 18'sd32767 : $signed({2'b00, dq.quo});
    end else begin
      spin = (dq.dovf || dq.quo > 16'd32768) ? -18'sd32768 : -$signed({2'b00, dq.quo});
    end
    hs_w = 18'(dq.hs);
    if (dq.near) begin
      hadj = hs_w;
    end else if (hs_w > -msh_pkg::PI_3) begin
      hadj = hs_w + spin;
    end else begin
      hadj = hs_w - spin;
    end
    f_next = dq;
    case (dq.sel)
      msh_pkg::ADJ_FIRST:  f_next.h1 = hadj;
      msh_pkg::ADJ_SECOND: f_next.h2 = hadj;
      default: ;
    endcase
  end

  logic           f_v;
  msh_pkg::item_t f;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_v <= 1'b0;
    end else if (adv) begin
      f_v <= dv_v[DV];
    end
    if (adv) begin
      f <= f_next;
    end
  end

  // ---- mix products
  logic [16:0]    wa;
  logic [16:0]    wb;
  msh_pkg::item_t g_next;

  always_comb begin
    wa  = msh_pkg::ONE_Q15 - {1'b0, f.r};
    wb  = {1'b0, f.r};
    g_next     = f;
    g_next.pm1 = 32'(f.m1 * wa);
    g_next.pm2 = 32'(f.m2 * wb);
    g_next.ps1 = 32'(f.s1 * wa);
    g_next.ps2 = 32'(f.s2 * wb);
    g_next.ph1 = f.h1 * $signed({1'b0, wa});
    g_next.ph2 = f.h2 * $signed({1'b0, wb});
  end

  logic           g_v;
  msh_pkg::item_t g;

  always_ff @(posedge clk) begin
    if (rst) begin
      g_v <= 1'b0;
    end else if (adv) begin
      g_v <= f_v;
    end
    if (adv) begin
      g <= g_next;
    end
  end

  // ---- sums, rounding shift, hue clamp
  logic [32:0]        msum;
  logic [32:0]        ssum;
  logic signed [36:0] hsum;
  logic signed [21:0] hsh;
  logic [15:0]        hout;

  always_comb begin
    msum = {1'b0, g.pm1} + {1'b0, g.pm2} + 33'd16384;
    ssum = {1'b0, g.ps1} + {1'b0, g.ps2} + 33'd16384;
    hsum = 37'(g.ph1) + 37'(g.ph2) + 37'sd16384;
    hsh  = hsum[36:15];
    if (hsh > 22'sd32767) begin
      hout = 16'h7fff;
    end else if (hsh < -22'sd32768) begin
      hout = 16'h8000;
    end else begin
      hout = hsh[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= g_v;
    end
    if (adv) begin
      m_tdata <= {hout, ssum[30:15], msum[30:15]};
    end
  end

  // ---- checks
  a_sqrt_root_fits: assert property (@(posedge clk) disable iff (rst)
    sq_v[SQ] |-> (sq_i[SQ].sq_res[31:16] == 16'd0))
    else $error("square root result exceeds 16 bits");

  a_div_remainder: assert property (@(posedge clk) disable iff (rst)
    (dv_v[DV] && !dv_i[DV].dovf) |-> (dv_i[DV].rem < {15'd0, dv_i[DV].dabs}))
    else $error("divider remainder not below divisor");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !adv |=> ($stable(a_v) && $stable(f_v) && $stable(g_v)))
    else $error("pipeline moved during a stall");

  a_zero_den_flag: assert property (@(posedge clk) disable iff (rst)
    (dv_v[0] && dv_i[0].dzero) |-> (dv_i[0].dabs == 32'd0))
    else $error("zero divisor flag disagrees with magnitude");

endmodule

// ===== bench/tb_msh_diverging_color_interpolator_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Msh diverging interpolator testbench
// Drives ratio words through the interpolator under several endpoint settings
// and compares each output word with an in-bench fixed-point model of the
// Msh path: bend through the neutral midpoint, hue spin and linear mix.
// ----------------------------------------------------------------------------
module tb_msh_diverging_color_interpolator_unit;

  localparam logic [2:0] REG_INDEX_UNUSED = 3'd7;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [47:0] m_tdata;
  logic        cfg_we;
  logic [2:0]  cfg_addr;
  logic [15:0] cfg_data;

  msh_diverging_color_interpolator_unit uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
  );

  typedef struct packed {
    logic [15:0] mag;
    logic [15:0] sat;
    logic [15:0] hue;
  } color_t;

  typedef struct {
    logic [15:0] ratio;
    logic        known;
    color_t      col;
  } row_t;

  // endpoint copy: magnitude, saturation, hue per end
  longint ep_m [2];
  longint ep_s [2];
  longint ep_h [2];

  color_t pending_colors[$];
  int     errors;
  bit     feeding_done;

  // arithmetic shift right with floor
  function automatic longint shr_floor(longint v, int n);
    return v >= 0 ? (v >>> n) : (-1 - ((-1 - v) >>> n));
  endfunction

  function automatic longint int_root(longint v);
    longint res, bitv;
    res = 0;
    bitv = 64'sd1 <<< 62;
    while (bitv > v) bitv = bitv >>> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >>> 1) + bitv;
      end else begin
        res = res >>> 1;
      end
      bitv = bitv >>> 2;
    end
    return res;
  endfunction

  function automatic longint cordic_sine(longint a);
    longint x, y, z, nx;
    x = msh_pkg::CORDIC_GAIN;
    y = 0;
    if (a > msh_pkg::PI_2) a = msh_pkg::PI_Q - a;
    z = a * 131072;
    for (int i = 0; i < msh_pkg::CORDIC_ITERATIONS && i < 24; i++) begin
      if (z >= 0) begin
        nx = x - shr_floor(y, i); y = y + shr_floor(x, i);
        z = z - msh_pkg::atan_at(5'(i));
      end else begin
        nx = x + shr_floor(y, i); y = y - shr_floor(x, i);
        z = z + msh_pkg::atan_at(5'(i));
      end
      x = nx;
    end
    return shr_floor(y + 16384, 15);
  endfunction

  function automatic longint spun_hue(longint ms, longint ss, longint hs, longint mu);
    longint root, num, den, spin;
    if (ms + msh_pkg::M_MARGIN >= mu) return hs;
    root = int_root(mu * mu - ms * ms);
    num = ss * root * 32768;
    den = ms * cordic_sine(ss);
    if (den == 0) spin = 32767;
    else begin
      spin = num / den;
      if (spin > 32767) spin = 32767;
      if (spin < -32768) spin = -32768;
    end
    return hs > -msh_pkg::PI_3 ? hs + spin : hs - spin;
  endfunction

  function automatic longint blend(longint a, longint b, longint r);
    return shr_floor(a * (32768 - r) + b * r + 16384, 15);
  endfunction

  function automatic color_t interpolate(logic [15:0] ratio);
    longint m1, s1, h1, m2, s2, h2, r, d, mid, ho;
    color_t c;
    m1 = ep_m[0]; s1 = ep_s[0]; h1 = ep_h[0];
    m2 = ep_m[1]; s2 = ep_s[1]; h2 = ep_h[1];
    r = ratio;
    if (r > 32768) r = 32768;
    d = (h1 - h2) % msh_pkg::TWO_PI;
    if (d < 0) d = d + msh_pkg::TWO_PI;
    if (d > msh_pkg::PI_Q) d = msh_pkg::TWO_PI - d;
    if (s1 > msh_pkg::S_THR && s2 > msh_pkg::S_THR && d > msh_pkg::PI_3) begin
      mid = m1 > m2 ? m1 : m2;
      if (mid < msh_pkg::MID_FLOOR) mid = msh_pkg::MID_FLOOR;
      if (r < 16384) begin
        m2 = mid; s2 = 0; h2 = 0; r = 2 * r;
      end else begin
        m1 = mid; s1 = 0; h1 = 0; r = 2 * r - 32768;
      end
    end
    if (s1 < msh_pkg::S_THR && s2 > msh_pkg::S_THR) h1 = spun_hue(m2, s2, h2, m1);
    else if (s2 < msh_pkg::S_THR && s1 > msh_pkg::S_THR) h2 = spun_hue(m1, s1, h1, m2);
    ho = blend(h1, h2, r);
    if (ho > 32767) ho = 32767;
    if (ho < -32768) ho = -32768;
    c.mag = 16'(blend(m1, m2, r));
    c.sat = 16'(blend(s1, s2, r));
    c.hue = 16'(ho);
    return c;
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      msh_pkg::REG_FIRST_MAGNITUDE:   ep_m[0] = val;
      msh_pkg::REG_FIRST_SATURATION:  ep_s[0] = val[14:0];
      msh_pkg::REG_FIRST_HUE:         ep_h[0] = $signed(val);
      msh_pkg::REG_SECOND_MAGNITUDE:  ep_m[1] = val;
      msh_pkg::REG_SECOND_SATURATION: ep_s[1] = val[14:0];
      msh_pkg::REG_SECOND_HUE:        ep_h[1] = $signed(val);
      default: ;
    endcase
  endtask

  task automatic set_ends(logic [15:0] m1, logic [15:0] s1, logic [15:0] h1,
                          logic [15:0] m2, logic [15:0] s2, logic [15:0] h2);
    write_reg(msh_pkg::REG_FIRST_MAGNITUDE, m1);
    write_reg(msh_pkg::REG_FIRST_SATURATION, s1);
    write_reg(msh_pkg::REG_FIRST_HUE, h1);
    write_reg(msh_pkg::REG_SECOND_MAGNITUDE, m2);
    write_reg(msh_pkg::REG_SECOND_SATURATION, s2);
    write_reg(msh_pkg::REG_SECOND_HUE, h2);
  endtask

  // hold off config writes until the pipeline has drained
  task automatic drain();
    while (pending_colors.size() != 0) @(negedge clk);
    repeat (70) @(negedge clk);
  endtask

  task automatic send_ratio(logic [15:0] ratio, bit known, color_t typed);
    color_t c;
    c = interpolate(ratio);
    if (known && c != typed) begin
      $error("typed row disagrees for ratio %0d", ratio);
      errors++;
    end
    pending_colors.push_back(c);
    s_tvalid <= 1'b1;
    s_tdata <= ratio;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_spaced(logic [15:0] ratio);
    color_t none;
    int g;
    g = gap_len();
    if (g != 0) begin
      s_tvalid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    send_ratio(ratio, 1'b0, none);
  endtask

  function automatic logic [15:0] rand_ratio();
    int p;
    p = $urandom_range(0, 19);
    if (p == 0) return 16'($urandom_range(32769, 65535));
    if (p == 1) return 16'($urandom_range(16382, 16386));
    return 16'($urandom_range(0, 32768));
  endfunction

  function automatic logic [15:0] rand_hue();
    return 16'($signed($urandom_range(0, 51472)) - 25736);
  endfunction

  function automatic logic [15:0] rand_sat();
    int p;
    p = $urandom_range(0, 9);
    if (p == 0) return 16'd410;
    if (p < 4) return 16'($urandom_range(0, 409));
    return 16'($urandom_range(411, 25736));
  endfunction

  // sink side: random backpressure and checking
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 199) < 3) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(10, 60)) @(negedge clk);
      end
      m_tready <= ($urandom_range(0, 99) < 75) || feeding_done;
    end
  end

  always @(posedge clk) begin
    color_t exp_c;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_colors.size() == 0) begin
        $error("unexpected output word %h", m_tdata);
        errors++;
      end else begin
        exp_c = pending_colors.pop_front();
        if (m_tdata[15:0] !== exp_c.mag) begin
          $error("out_magnitude expected %h got %h", exp_c.mag, m_tdata[15:0]);
          errors++;
        end
        if (m_tdata[31:16] !== exp_c.sat) begin
          $error("out_saturation expected %h got %h", exp_c.sat, m_tdata[31:16]);
          errors++;
        end
        if (m_tdata[47:32] !== exp_c.hue) begin
          $error("out_hue expected %h got %h", exp_c.hue, m_tdata[47:32]);
          errors++;
        end
      end
    end
  end

  initial begin
    row_t dir_rows[$];
    row_t rw;
    int wait_cycles;
    errors = 0;
    feeding_done = 1'b0;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    cfg_we = 1'b0;
    cfg_addr = '0;
    cfg_data = '0;
    for (int e = 0; e < 2; e++) begin
      ep_m[e] = 0; ep_s[e] = 0; ep_h[e] = 0;
    end
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // after reset every field is zero
    rw.known = 1'b1; rw.col.mag = 0; rw.col.sat = 0; rw.col.hue = 0;
    rw.ratio = 16'd0;     dir_rows.push_back(rw);
    rw.ratio = 16'd32768; dir_rows.push_back(rw);
    rw.ratio = 16'hFFFF;  dir_rows.push_back(rw);
    foreach (dir_rows[i]) send_ratio(dir_rows[i].ratio, dir_rows[i].known, dir_rows[i].col);
    s_tvalid <= 1'b0;
    drain();

    // extremes: endpoints read back at ratio zero and one
    set_ends(16'hFFFF, 16'd0, 16'h8000, 16'd0, 16'd0, 16'h7FFF);
    dir_rows.delete();
    rw.known = 1'b1;
    rw.ratio = 16'd0;     rw.col = '{16'hFFFF, 16'd0, 16'h8000}; dir_rows.push_back(rw);
    rw.ratio = 16'd32768; rw.col = '{16'd0, 16'd0, 16'h7FFF};    dir_rows.push_back(rw);
    rw.ratio = 16'd40000; dir_rows.push_back(rw);
    rw.known = 1'b0;
    rw.ratio = 16'd16384; dir_rows.push_back(rw);
    foreach (dir_rows[i]) send_ratio(dir_rows[i].ratio, dir_rows[i].known, dir_rows[i].col);
    s_tvalid <= 1'b0;
    drain();

    // bend through midpoint, both sides and the split point
    set_ends(16'd8000, 16'd25736, 16'hE778, 16'd9000, 16'd20000, 16'd25736);
    send_spaced(16'd0); send_spaced(16'd16383); send_spaced(16'd16384);
    send_spaced(16'd32768);
    s_tvalid <= 1'b0;
    drain();
    // spin: unsaturated first end, large magnitude
    set_ends(16'd40000, 16'd0, 16'd0, 16'd5000, 16'd12868, 16'hD000);
    send_spaced(16'd0); send_spaced(16'd20000);
    s_tvalid <= 1'b0;
    drain();
    write_reg(REG_INDEX_UNUSED, 16'h1234); // unknown index ignored
    // zero magnitude on saturated end: zero divisor
    set_ends(16'd100, 16'd0, 16'd0, 16'd0, 16'd25736, 16'd25736);
    send_spaced(16'd0); send_spaced(16'd32768);
    s_tvalid <= 1'b0;
    drain();
    set_ends(16'd60000, 16'd1, 16'd0, 16'd3, 16'd25735, 16'h9B78);
    send_spaced(16'd0); send_spaced(16'd9999);
    s_tvalid <= 1'b0;
    drain();

    // random phases
    for (int ph = 0; ph < 10; ph++) begin
      set_ends(16'($urandom_range(0, 65535)), rand_sat(), rand_hue(),
               16'($urandom_range(0, 65535)), rand_sat(), rand_hue());
      if ($urandom_range(0, 1))
        write_reg(msh_pkg::REG_FIRST_SATURATION, 16'($urandom_range(0, 409)));
      for (int k = 0; k < 40; k++) begin
        if (ph % 3 == 0) send_ratio(rand_ratio(), 1'b0, rw.col);
        else send_spaced(rand_ratio());
      end
      s_tvalid <= 1'b0;
      drain();
    end

    feeding_done = 1'b1;
    wait_cycles = 0;
    while (pending_colors.size() != 0 && wait_cycles < 20000) begin
      @(negedge clk);
      wait_cycles++;
    end
    repeat (70) @(negedge clk);
    if (errors == 0 && pending_colors.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
